// ===== src/lsc3d_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc3d_pkg
// types, constants and helper functions of the 3d segment clipper
// ----------------------------------------------------------------------------
package lsc3d_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int NUM_LANES  = 6;
    localparam int NUM_FACES  = 6;
    localparam int QUO_BITS   = 25;
    localparam int PROD_BITS  = 50;

    localparam logic signed [25:0] ONE = 26'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic signed [23:0] start_z;
        logic signed [23:0] end_x;
        logic signed [23:0] end_y;
        logic signed [23:0] end_z;
        logic [15:0]        start_red;
        logic [15:0]        start_green;
        logic [15:0]        start_blue;
        logic [15:0]        end_red;
        logic [15:0]        end_green;
        logic [15:0]        end_blue;
    } in_t;

    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic signed [23:0] point_z;
        logic [15:0]        point_red;
        logic [15:0]        point_green;
        logic [15:0]        point_blue;
        logic               is_end_point;
        logic               visible;
        logic               color_interpolated;
    } out_t;

    typedef struct packed {
        logic signed [25:0] n;
        logic signed [25:0] d;
    } frac_t;

    typedef struct packed {
        in_t   item;
        frac_t te;
        frac_t tl;
        logic  vis;
    } cls_t;

    typedef struct packed {
        frac_t te;
        frac_t tl;
        logic  pass;
    } face_t;

    typedef struct packed {
        logic [24:0]        dmag;
        logic               neg;
        logic [24:0]        tn;
        logic [24:0]        td;
        logic signed [24:0] base;
    } lane0_t;

    typedef struct packed {
        logic [PROD_BITS-1:0] rem;
        logic [QUO_BITS-1:0]  quo;
        logic [24:0]          td;
        logic                 neg;
        logic signed [24:0]   base;
    } div_t;

    typedef struct packed {
        logic is_end;
        logic vis;
        logic moved;
    } meta_t;

    function automatic logic signed [24:0] lane_start(in_t it, logic [2:0] lane);
        logic signed [24:0] r;
        case (lane)
            3'd0:    r = 25'(it.start_x);
            3'd1:    r = 25'(it.start_y);
            3'd2:    r = 25'(it.start_z);
            3'd3:    r = {9'd0, it.start_red};
            3'd4:    r = {9'd0, it.start_green};
            3'd5:    r = {9'd0, it.start_blue};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [24:0] lane_end(in_t it, logic [2:0] lane);
        logic signed [24:0] r;
        case (lane)
            3'd0:    r = 25'(it.end_x);
            3'd1:    r = 25'(it.end_y);
            3'd2:    r = 25'(it.end_z);
            3'd3:    r = {9'd0, it.end_red};
            3'd4:    r = {9'd0, it.end_green};
            3'd5:    r = {9'd0, it.end_blue};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic face_t face_step(logic signed [25:0] p, logic signed [25:0] q,
                                        frac_t te, frac_t tl);
        face_t              r;
        logic signed [25:0] tn;
        logic signed [25:0] td;
        logic signed [51:0] m_ln;
        logic signed [51:0] m_lr;
        logic signed [51:0] m_en;
        logic signed [51:0] m_er;
        r.te   = te;
        r.tl   = tl;
        r.pass = 1'b1;
        tn     = (p < 0) ? -q : q;
        td     = (p < 0) ? -p : p;
        m_ln   = tn * tl.d;
        m_lr   = tl.n * td;
        m_en   = tn * te.d;
        m_er   = te.n * td;
        if (p > 0) begin
            if (m_ln > m_lr) r.pass = 1'b0;
            if (m_en > m_er) begin
                r.te.n = tn;
                r.te.d = td;
            end
        end else if (p < 0) begin
            if (m_en < m_er) r.pass = 1'b0;
            if (m_ln < m_lr) begin
                r.tl.n = tn;
                r.tl.d = td;
            end
        end else if (q > 0) begin
            r.pass = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== src/lsc3d_front.sv =====
// ----------------------------------------------------------------------------
// lsc3d_front
// six stage face test pipeline, one face per stage, builds entry and exit params
// ----------------------------------------------------------------------------
module lsc3d_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lsc3d_pkg::in_t      s_data,
    output logic                f_valid,
    input  logic                f_ready,
    output lsc3d_pkg::cls_t     f_data
);

    lsc3d_pkg::cls_t st_reg  [lsc3d_pkg::NUM_FACES];
    lsc3d_pkg::cls_t st_next [lsc3d_pkg::NUM_FACES];
    logic [lsc3d_pkg::NUM_FACES-1:0] vld_reg, vld_next;
    logic en;

    assign en      = !vld_reg[lsc3d_pkg::NUM_FACES-1] || f_ready;
    assign s_ready = en;
    assign f_valid = vld_reg[lsc3d_pkg::NUM_FACES-1];
    assign f_data  = st_reg[lsc3d_pkg::NUM_FACES-1];

    always_comb begin
        lsc3d_pkg::cls_t    src;
        lsc3d_pkg::face_t   fr;
        logic signed [24:0] a0;
        logic signed [24:0] a1;
        logic signed [25:0] d;
        logic signed [25:0] p;
        logic signed [25:0] q;
        for (int s = 0; s < lsc3d_pkg::NUM_FACES; s++) begin
            if (s == 0) begin
                src.item = s_data;
                src.te.n = '0;
                src.te.d = 26'sd1;
                src.tl.n = 26'sd1;
                src.tl.d = 26'sd1;
                src.vis  = 1'b1;
                vld_next[s] = s_valid;
            end else begin
                src = st_reg[s-1];
                vld_next[s] = vld_reg[s-1];
            end
            a0 = lsc3d_pkg::lane_start(src.item, 3'(s / 2));
            a1 = lsc3d_pkg::lane_end(src.item, 3'(s / 2));
            d  = 26'(a1) - 26'(a0);
            if (s % 2 == 0) begin
                p = d;
                q = -lsc3d_pkg::ONE - 26'(a0);
            end else begin
                p = -d;
                q = 26'(a0) - lsc3d_pkg::ONE;
            end
            fr = lsc3d_pkg::face_step(p, q, src.te, src.tl);
            st_next[s].item = src.item;
            st_next[s].te   = fr.te;
            st_next[s].tl   = fr.tl;
            st_next[s].vis  = src.vis & fr.pass;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < lsc3d_pkg::NUM_FACES; s++) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

endmodule

// ===== src/lsc3d_fifo.sv =====
// ----------------------------------------------------------------------------
// lsc3d_fifo
// short queue of classified segments between front and back
// ----------------------------------------------------------------------------
module lsc3d_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  lsc3d_pkg::cls_t wr_data,
    output logic            rd_valid,
    input  logic            rd_pop,
    output lsc3d_pkg::cls_t rd_data
);

    lsc3d_pkg::cls_t mem_reg [lsc3d_pkg::FIFO_DEPTH];
    logic [lsc3d_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [lsc3d_pkg::FIFO_AW:0]   cnt_reg, cnt_next;
    logic push, pop;

    assign wr_ready = cnt_reg != (lsc3d_pkg::FIFO_AW+1)'(lsc3d_pkg::FIFO_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (lsc3d_pkg::FIFO_AW+1)'(push) - (lsc3d_pkg::FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/lsc3d_back.sv =====
// ----------------------------------------------------------------------------
// lsc3d_back
// emits start then end result, interpolating through a bit per stage divider
// ----------------------------------------------------------------------------
module lsc3d_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_pop,
    input  lsc3d_pkg::cls_t q_data,
    output logic            m_valid,
    input  logic            m_ready,
    output lsc3d_pkg::out_t m_data
);

    localparam int NDV = lsc3d_pkg::QUO_BITS + 1;
    localparam int NL  = lsc3d_pkg::NUM_LANES;
    localparam int PROD_BITS_W = lsc3d_pkg::PROD_BITS;

    lsc3d_pkg::lane0_t l0_reg  [NL];
    lsc3d_pkg::lane0_t l0_next [NL];
    lsc3d_pkg::div_t   dv_reg  [NDV][NL];
    lsc3d_pkg::div_t   dv_next [NDV][NL];
    lsc3d_pkg::meta_t  m0_reg, m0_next;
    lsc3d_pkg::meta_t  mdv_reg [NDV];
    lsc3d_pkg::out_t   out_reg, out_next;
    logic              v0_reg;
    logic [NDV-1:0]    vdv_reg;
    logic              vout_reg;
    logic              phase_reg, phase_next;
    logic              en, issue;

    assign en      = !vout_reg || m_ready;
    assign issue   = en && q_valid;
    assign q_pop   = issue && phase_reg;
    assign m_valid = vout_reg;
    assign m_data  = out_reg;

    always_comb begin
        lsc3d_pkg::frac_t   t;
        logic               mv;
        logic signed [24:0] a;
        logic signed [24:0] b;
        logic signed [24:0] dl;
        logic [PROD_BITS_W-1:0] sh;
        logic signed [24:0] sq;
        logic signed [24:0] r [NL];
        phase_next = issue ? !phase_reg : phase_reg;
        t  = phase_reg ? q_data.tl : q_data.te;
        mv = q_data.vis && (phase_reg ? (q_data.tl.n < q_data.tl.d) : (q_data.te.n > 0));
        m0_next.is_end = phase_reg;
        m0_next.vis    = q_data.vis;
        m0_next.moved  = mv;
        for (int l = 0; l < NL; l++) begin
            a  = lsc3d_pkg::lane_start(q_data.item, 3'(l));
            b  = lsc3d_pkg::lane_end(q_data.item, 3'(l));
            dl = b - a;
            l0_next[l].neg  = dl[24];
            l0_next[l].dmag = dl[24] ? 25'(-dl) : 25'(dl);
            l0_next[l].tn   = mv ? t.n[24:0] : '0;
            l0_next[l].td   = mv ? t.d[24:0] : 25'd1;
            l0_next[l].base = (mv || !phase_reg) ? a : b;
        end
        for (int l = 0; l < NL; l++) begin
            dv_next[0][l].rem  = l0_reg[l].dmag * l0_reg[l].tn;
            dv_next[0][l].quo  = '0;
            dv_next[0][l].td   = l0_reg[l].td;
            dv_next[0][l].neg  = l0_reg[l].neg;
            dv_next[0][l].base = l0_reg[l].base;
        end
        for (int k = 1; k < NDV; k++) begin
            for (int l = 0; l < NL; l++) begin
                dv_next[k][l] = dv_reg[k-1][l];
                sh = PROD_BITS_W'(dv_reg[k-1][l].td) << (NDV - 1 - k);
                if (dv_reg[k-1][l].rem >= sh) begin
                    dv_next[k][l].rem = dv_reg[k-1][l].rem - sh;
                    dv_next[k][l].quo[NDV-1-k] = 1'b1;
                end
            end
        end
        for (int l = 0; l < NL; l++) begin
            sq   = dv_reg[NDV-1][l].quo;
            r[l] = dv_reg[NDV-1][l].base + (dv_reg[NDV-1][l].neg ? -sq : sq);
        end
        out_next.point_x            = r[0][23:0];
        out_next.point_y            = r[1][23:0];
        out_next.point_z            = r[2][23:0];
        out_next.point_red          = r[3][15:0];
        out_next.point_green        = r[4][15:0];
        out_next.point_blue         = r[5][15:0];
        out_next.is_end_point       = mdv_reg[NDV-1].is_end;
        out_next.visible            = mdv_reg[NDV-1].vis;
        out_next.color_interpolated = mdv_reg[NDV-1].moved;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg    <= 1'b0;
            vdv_reg   <= '0;
            vout_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end else if (en) begin
            v0_reg    <= q_valid;
            vdv_reg   <= {vdv_reg[NDV-2:0], v0_reg};
            vout_reg  <= vdv_reg[NDV-1];
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m0_reg     <= m0_next;
            mdv_reg[0] <= m0_reg;
            for (int k = 1; k < NDV; k++) begin
                mdv_reg[k] <= mdv_reg[k-1];
            end
            for (int l = 0; l < NL; l++) begin
                l0_reg[l] <= l0_next[l];
            end
            for (int k = 0; k < NDV; k++) begin
                for (int l = 0; l < NL; l++) begin
                    dv_reg[k][l] <= dv_next[k][l];
                end
            end
            out_reg <= out_next;
        end
    end

endmodule

// ===== src/line_segment_clipper_3d_unit.sv =====
// ----------------------------------------------------------------------------
// line_segment_clipper_3d_unit
// liang-barsky clipping of a colored 3d segment against the unit cube
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one segment per beat (two points, two colors).
//   m_ channel gives two beats per segment: start point, then end point,
//   each with visible and color_interpolated flags.
//   from input beat to the start result a segment passes 6 face test stages,
//   1 queue stage and 28 back stages incl. output register.
//   throughput: the front takes one segment per cycle into a 4 entry queue
//   unless stalled by a full queue; the back emits one result per cycle unless
//   m_ready stalls it, so the sustained rate is set by the two results per segment.
//   a stall on m_ready freezes the back pipeline; the front keeps accepting
//   until the queue is full and a segment waits in its last stage, then
//   s_ready drops.
//   reset clears all valid bits and the result phase; no results are pending.
// ----------------------------------------------------------------------------
module line_segment_clipper_3d_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  lsc3d_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output lsc3d_pkg::out_t m_data
);

    logic            f_valid, f_ready, q_valid, q_pop;
    lsc3d_pkg::cls_t f_data, q_data;

    lsc3d_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_data  (f_data)
    );

    lsc3d_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_data)
    );

    lsc3d_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    a_no_interp_when_hidden: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.visible |-> !m_data.color_interpolated)
        else $error("interpolated color on hidden segment");

    a_idle_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> f_valid && !f_ready)
        else $error("input stalled without full queue");
`endif

endmodule
